FILE: src/crtbp_pkg.sv
// ----------------------------------------------------------------------------
// crtbp_pkg
// Widths, pipeline timing, shared types and helpers for the three-body
// state derivative pipeline.
// ----------------------------------------------------------------------------
package crtbp_pkg;

  localparam int QW  = 48;        // Q8.40 state word
  localparam int DW  = 50;        // signed offset from a primary
  localparam int MW  = 49;        // magnitude of an offset
  localparam int SW  = 99;        // sum of squares, Q19.80
  localparam int EW  = 100;       // root residual
  localparam int RW  = 49;        // root bits
  localparam int CW  = 107;       // distance cube, Q28.79
  localparam int KW  = 41;        // coefficient, Q0.40 plus one
  localparam int UW  = 40;        // mass ratio register
  localparam int NW  = 89;        // coefficient times magnitude
  localparam int QB  = 51;        // quotient bits kept
  localparam int LW  = 25;        // multiplier limb
  localparam int TW  = 53;        // acceleration sum
  localparam int NTERM = 6;

  localparam int CUBE_SHIFT = 41;
  localparam int NUM_SHIFT  = 39;

  localparam logic [UW-1:0] MU_RESET = 40'd3301833;
  localparam logic [KW-1:0] ONE_Q40  = {1'b1, {(KW-1){1'b0}}};
  localparam logic [QB-1:0] TERM_LIMIT = {1'b1, {(QB-1){1'b0}}};

  localparam logic signed [TW-1:0] ACC_HI =
    signed'({{(TW-QW+1){1'b0}}, {(QW-1){1'b1}}});
  localparam logic signed [TW-1:0] ACC_LO =
    signed'({{(TW-QW+1){1'b1}}, {(QW-1){1'b0}}});

  // module latencies
  localparam int LAT_SQ   = 2;
  localparam int LAT_NUM  = 2;
  localparam int LAT_CMUL = 3;
  localparam int LAT_DIST = RW + LAT_CMUL;
  localparam int LAT_DIV  = QB + 1;

  // pipeline stage numbers, input register is stage 0
  localparam int ST_MAG     = 1;
  localparam int ST_NUM_OUT = ST_MAG + LAT_NUM;
  localparam int ST_SUM     = ST_MAG + LAT_SQ + 1;
  localparam int ST_DIV_IN  = ST_SUM + LAT_DIST;
  localparam int ST_DIV_OUT = ST_DIV_IN + LAT_DIV;
  localparam int ST_OUT     = ST_DIV_OUT + 1;
  localparam int NUM_DLY    = ST_DIV_IN - ST_NUM_OUT;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] vx;
    logic signed [QW-1:0] vy;
    logic signed [QW-1:0] vz;
    logic sd1;
    logic sd2;
    logic sy;
    logic sz;
  } side_t;

  typedef struct packed {
    logic [QB-1:0] q;
    logic          clip;
    logic          dz;
  } divres_t;

  function automatic logic signed [TW-1:0] term(input logic [QB-1:0] q, input logic neg);
    logic signed [TW-1:0] m;
    m = signed'(TW'(q));
    return neg ? -m : m;
  endfunction

  // {clipped, value}
  function automatic logic [QW:0] sat_acc(input logic signed [TW-1:0] v);
    logic [QW:0] r;
    if (v > ACC_HI) begin
      r = {1'b1, 1'b0, {(QW-1){1'b1}}};
    end else if (v < ACC_LO) begin
      r = {1'b1, 1'b1, {(QW-1){1'b0}}};
    end else begin
      r = {1'b0, v[QW-1:0]};
    end
    return r;
  endfunction

endpackage

FILE: src/crtbp_state_derivative_top.sv
// ----------------------------------------------------------------------------
// crtbp_state_derivative_top
// Rotating-frame three-body state derivative, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries one state (position and velocity, signed Q8.40) on
//   req_valid/req_ready. The result carries the velocity as position
//   derivative, the saturated acceleration and a saturation flag on
//   res_valid/res_ready.
//   Latency from acceptance to res_valid is set by the 49-stage
//   square root and the 52-stage term divider in series.
//   Throughput is one state per cycle while the output is not stalled.
//   The whole pipeline advances together: when res_valid is high and
//   res_ready low, every stage holds and req_ready drops, so nothing is
//   lost or repeated. A bubble at the output lets the pipeline advance.
//   Reset empties the pipeline and loads the default mass ratio (Sun-Earth).
//   cfg_write loads the mass ratio from cfg_data; write it only while no
//   request is in flight.
// ----------------------------------------------------------------------------
module crtbp_state_derivative_top import crtbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [UW-1:0]        cfg_data,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic signed [QW-1:0] pos_x,
  input  logic signed [QW-1:0] pos_y,
  input  logic signed [QW-1:0] pos_z,
  input  logic signed [QW-1:0] vel_x,
  input  logic signed [QW-1:0] vel_y,
  input  logic signed [QW-1:0] vel_z,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic signed [QW-1:0] dpos_x,
  output logic signed [QW-1:0] dpos_y,
  output logic signed [QW-1:0] dpos_z,
  output logic signed [QW-1:0] acc_x,
  output logic signed [QW-1:0] acc_y,
  output logic signed [QW-1:0] acc_z,
  output logic                 saturated
);

  logic                adv;
  logic [ST_OUT:0]     v;
  logic [UW-1:0]       mu;

  logic signed [DW-1:0] d1_in;
  logic signed [DW-1:0] d2_in;

  // stage 0
  logic signed [DW-1:0] d1;
  logic signed [DW-1:0] d2;
  logic signed [QW-1:0] y0;
  logic signed [QW-1:0] z0;
  logic [UW-1:0]        mu0;
  logic [KW-1:0]        c10;

  // stage 1
  logic [MW-1:0] md1;
  logic [MW-1:0] md2;
  logic [MW-1:0] my;
  logic [MW-1:0] mz;
  logic [KW-1:0] mu1;
  logic [KW-1:0] c11;

  logic [2*MW-1:0] sq_d1;
  logic [2*MW-1:0] sq_d2;
  logic [2*MW-1:0] sq_y;
  logic [2*MW-1:0] sq_z;
  logic [SW-1:0]   s1;
  logic [SW-1:0]   s2;
  logic [CW-1:0]   cube1;
  logic [CW-1:0]   cube2;

  side_t side [0:ST_DIV_OUT];

  logic [NTERM-1:0][NW-1:0] num_out;
  logic [NTERM-1:0][NW-1:0] nd [1:NUM_DLY];
  logic [KW-1:0]            tcoef [NTERM];
  logic [MW-1:0]            tmag  [NTERM];
  divres_t                  dres  [NTERM];

  logic signed [TW-1:0] ax;
  logic signed [TW-1:0] ay;
  logic signed [TW-1:0] az;
  logic [QW:0]          sx;
  logic [QW:0]          sy;
  logic [QW:0]          sz;
  logic                 flag;

  assign adv       = !v[ST_OUT] || res_ready;
  assign req_ready = adv;
  assign res_valid = v[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      mu <= MU_RESET;
    end else if (cfg_write) begin
      mu <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[ST_OUT-1:0], req_valid};
    end
  end

  assign d1_in = DW'(pos_x) + signed'(DW'(mu));
  assign d2_in = DW'(pos_x) - signed'(DW'(ONE_Q40)) + signed'(DW'(mu));

  always_ff @(posedge clk) begin
    if (adv) begin
      d1  <= d1_in;
      d2  <= d2_in;
      y0  <= pos_y;
      z0  <= pos_z;
      mu0 <= mu;
      c10 <= ONE_Q40 - KW'(mu);
      side[0].x   <= pos_x;
      side[0].y   <= pos_y;
      side[0].vx  <= vel_x;
      side[0].vy  <= vel_y;
      side[0].vz  <= vel_z;
      side[0].sd1 <= d1_in[DW-1];
      side[0].sd2 <= d2_in[DW-1];
      side[0].sy  <= pos_y[QW-1];
      side[0].sz  <= pos_z[QW-1];

      md1 <= d1[DW-1] ? MW'(-d1) : MW'(d1);
      md2 <= d2[DW-1] ? MW'(-d2) : MW'(d2);
      my  <= y0[QW-1] ? MW'(-MW'(y0)) : MW'(y0);
      mz  <= z0[QW-1] ? MW'(-MW'(z0)) : MW'(z0);
      mu1 <= KW'(mu0);
      c11 <= c10;

      s1 <= SW'(sq_d1) + SW'(sq_y) + SW'(sq_z);
      s2 <= SW'(sq_d2) + SW'(sq_y) + SW'(sq_z);

      nd[1] <= num_out;
      for (int k = 2; k <= NUM_DLY; k++) begin
        nd[k] <= nd[k-1];
      end
      for (int k = 1; k <= ST_DIV_OUT; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  crtbp_sq u_sq_d1 (.clk(clk), .en(adv), .a(md1), .sq(sq_d1));
  crtbp_sq u_sq_d2 (.clk(clk), .en(adv), .a(md2), .sq(sq_d2));
  crtbp_sq u_sq_y  (.clk(clk), .en(adv), .a(my),  .sq(sq_y));
  crtbp_sq u_sq_z  (.clk(clk), .en(adv), .a(mz),  .sq(sq_z));

  crtbp_dist u_dist1 (.clk(clk), .en(adv), .s(s1), .cube(cube1));
  crtbp_dist u_dist2 (.clk(clk), .en(adv), .s(s2), .cube(cube2));

  // terms 0..2 about the larger primary, 3..5 about the smaller one
  assign tcoef[0] = c11;
  assign tcoef[1] = c11;
  assign tcoef[2] = c11;
  assign tcoef[3] = mu1;
  assign tcoef[4] = mu1;
  assign tcoef[5] = mu1;
  assign tmag[0]  = md1;
  assign tmag[1]  = my;
  assign tmag[2]  = mz;
  assign tmag[3]  = md2;
  assign tmag[4]  = my;
  assign tmag[5]  = mz;

  for (genvar i = 0; i < NTERM; i++) begin : g_term
    crtbp_num u_num (
      .clk  (clk),
      .en   (adv),
      .coef (tcoef[i]),
      .m    (tmag[i]),
      .num  (num_out[i])
    );
    crtbp_div u_div (
      .clk (clk),
      .en  (adv),
      .num (nd[NUM_DLY][i]),
      .den ((i < 3) ? cube1 : cube2),
      .res (dres[i])
    );
  end

  always_comb begin
    ax = (TW'(side[ST_DIV_OUT].vy) <<< 1) + TW'(side[ST_DIV_OUT].x)
       - term(dres[0].q, side[ST_DIV_OUT].sd1) - term(dres[3].q, side[ST_DIV_OUT].sd2);
    ay = TW'(side[ST_DIV_OUT].y) - (TW'(side[ST_DIV_OUT].vx) <<< 1)
       - term(dres[1].q, side[ST_DIV_OUT].sy) - term(dres[4].q, side[ST_DIV_OUT].sy);
    az = -term(dres[2].q, side[ST_DIV_OUT].sz) - term(dres[5].q, side[ST_DIV_OUT].sz);
    sx = sat_acc(ax);
    sy = sat_acc(ay);
    sz = sat_acc(az);
    flag = dres[0].dz || dres[3].dz || sx[QW] || sy[QW] || sz[QW];
    for (int i = 0; i < NTERM; i++) begin
      flag = flag || dres[i].clip;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dpos_x    <= side[ST_DIV_OUT].vx;
      dpos_y    <= side[ST_DIV_OUT].vy;
      dpos_z    <= side[ST_DIV_OUT].vz;
      acc_x     <= signed'(sx[QW-1:0]);
      acc_y     <= signed'(sy[QW-1:0]);
      acc_z     <= signed'(sz[QW-1:0]);
      saturated <= flag;
    end
  end

`ifndef SYNTHESIS
  a_term_limit: assert property (@(posedge clk) disable iff (rst)
    v[ST_DIV_OUT] |-> (dres[0].q <= TERM_LIMIT && dres[1].q <= TERM_LIMIT &&
      dres[2].q <= TERM_LIMIT && dres[3].q <= TERM_LIMIT &&
      dres[4].q <= TERM_LIMIT && dres[5].q <= TERM_LIMIT))
    else $error("gravity term above limit");

  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    (v[ST_DIV_OUT] && adv && (dres[0].dz || dres[3].dz)) |=> saturated)
    else $error("zero distance not flagged");

  a_clip_flag: assert property (@(posedge clk) disable iff (rst)
    (v[ST_DIV_OUT] && adv && (dres[0].clip || dres[1].clip || dres[2].clip ||
      dres[3].clip || dres[4].clip || dres[5].clip)) |=> saturated)
    else $error("clipped term not flagged");
`endif

endmodule

FILE: src/crtbp_sq.sv
// ----------------------------------------------------------------------------
// crtbp_sq
// Two-stage squarer of an offset magnitude, split into a 25-bit low limb and a 24-bit high limb.
// ----------------------------------------------------------------------------
module crtbp_sq import crtbp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [MW-1:0]     a,
  output logic [2*MW-1:0]   sq
);

  logic [LW-1:0]          a0;
  logic [MW-LW-1:0]       a1;
  logic [2*LW-1:0]        p00;
  logic [MW-1:0]          p01;
  logic [2*(MW-LW)-1:0]   p11;

  assign a0 = a[LW-1:0];
  assign a1 = a[MW-1:LW];

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= a0 * a0;
      p01 <= a1 * a0;
      p11 <= a1 * a1;
      sq  <= {p11, {(2*LW){1'b0}}} + ((2*MW)'(p01) << (LW+1)) + (2*MW)'(p00);
    end
  end

endmodule

FILE: src/crtbp_num.sv
// ----------------------------------------------------------------------------
// crtbp_num
// Two-stage product of a mass coefficient and an offset magnitude.
// ----------------------------------------------------------------------------
module crtbp_num import crtbp_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [KW-1:0]   coef,
  input  logic [MW-1:0]   m,
  output logic [NW-1:0]   num
);

  logic [LW-1:0]              c0;
  logic [KW-LW-1:0]           c1;
  logic [LW-1:0]              m0;
  logic [MW-LW-1:0]           m1;
  logic [2*LW-1:0]            p00;
  logic [MW-1:0]              p01;
  logic [KW-1:0]              p10;
  logic [KW+MW-2*LW-1:0]      p11;
  logic [NW:0]                acc;

  assign c0 = coef[LW-1:0];
  assign c1 = coef[KW-1:LW];
  assign m0 = m[LW-1:0];
  assign m1 = m[MW-1:LW];

  always_comb begin
    acc = {p11, {(2*LW){1'b0}}} + ((NW+1)'(p01) << LW) + ((NW+1)'(p10) << LW)
        + (NW+1)'(p00);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= c0 * m0;
      p01 <= c0 * m1;
      p10 <= c1 * m0;
      p11 <= c1 * m1;
      num <= acc[NW-1:0];
    end
  end

endmodule

FILE: src/crtbp_dist.sv
// ----------------------------------------------------------------------------
// crtbp_dist
// Distance cube: one root bit per stage, then a three-stage product of the
// sum of squares and the root, scaled down to Q28.79.
// ----------------------------------------------------------------------------
module crtbp_dist import crtbp_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [SW-1:0]   s,
  output logic [CW-1:0]   cube
);

  logic [EW-1:0] e  [1:RW];
  logic [RW-1:0] r  [1:RW];
  logic [SW-1:0] sv [1:RW];

  for (genvar j = 0; j < RW; j++) begin : g_root
    localparam int B = RW - 1 - j;
    logic [EW-1:0] ei;
    logic [RW-1:0] ri;
    logic [SW-1:0] si;
    logic [EW-1:0] t;
    if (j == 0) begin : g_first
      assign ei = EW'(s);
      assign ri = '0;
      assign si = s;
    end else begin : g_rest
      assign ei = e[j];
      assign ri = r[j];
      assign si = sv[j];
    end
    assign t = (EW'(ri) << (B+1)) + (EW'(1) << (2*B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (ei >= t) begin
          e[j+1] <= ei - t;
          r[j+1] <= ri | (RW'(1) << B);
        end else begin
          e[j+1] <= ei;
          r[j+1] <= ri;
        end
        sv[j+1] <= si;
      end
    end
  end

  logic [4*LW-1:0] sp;
  logic [2*LW-1:0] rp;
  logic [2*LW-1:0] p  [4][2];
  logic [5*LW-1:0] pj [2];
  logic [5*LW-1:0] pj_next [2];
  logic [6*LW-1:0] prod;

  assign sp = (4*LW)'(sv[RW]);
  assign rp = (2*LW)'(r[RW]);

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      pj_next[j] = '0;
      for (int i = 0; i < 4; i++) begin
        pj_next[j] = pj_next[j] + ((5*LW)'(p[i][j]) << (LW*i));
      end
    end
    prod = (6*LW)'(pj[0]) + ((6*LW)'(pj[1]) << LW);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          p[i][j] <= sp[i*LW +: LW] * rp[j*LW +: LW];
        end
      end
      pj[0] <= pj_next[0];
      pj[1] <= pj_next[1];
      cube  <= prod[CW+CUBE_SHIFT-1:CUBE_SHIFT];
    end
  end

endmodule

FILE: src/crtbp_div.sv
// ----------------------------------------------------------------------------
// crtbp_div
// Gravity term magnitude: restoring division of coef*|comp|*2^39 by the
// distance cube, one quotient bit per stage, clipped to 2^50.
// ----------------------------------------------------------------------------
module crtbp_div import crtbp_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   num,
  input  logic [CW-1:0]   den,
  output divres_t         res
);

  localparam int RMW = CW + 1;
  localparam int HW  = NW + NUM_SHIFT - QB;

  logic [RMW-1:0] rem  [0:QB];
  logic [QB-1:0]  q    [0:QB];
  logic [QB-1:0]  low  [0:QB];
  logic [CW-1:0]  dn   [0:QB];
  logic           ovf  [0:QB];
  logic           nz   [0:QB];
  logic           dz   [0:QB];

  logic [HW-1:0]  hi;
  logic           big;

  assign hi = num[NW-1:QB-NUM_SHIFT];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RMW'(hi);
      ovf[0] <= RMW'(hi) >= RMW'(den);
      nz[0]  <= num != '0;
      dz[0]  <= den == '0;
      dn[0]  <= den;
      low[0] <= {num[QB-NUM_SHIFT-1:0], {NUM_SHIFT{1'b0}}};
      q[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [RMW-1:0] sh;
    assign sh = {rem[k-1][RMW-2:0], low[k-1][QB-k]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (sh >= RMW'(dn[k-1])) begin
          rem[k] <= sh - RMW'(dn[k-1]);
          q[k]   <= q[k-1] | (QB'(1) << (QB-k));
        end else begin
          rem[k] <= sh;
          q[k]   <= q[k-1];
        end
        ovf[k] <= ovf[k-1];
        nz[k]  <= nz[k-1];
        dz[k]  <= dz[k-1];
        dn[k]  <= dn[k-1];
        low[k] <= low[k-1];
      end
    end
  end

  assign big = q[QB][QB-1] && (q[QB][QB-2:0] != '0);

  always_comb begin
    res.dz   = dz[QB];
    res.clip = nz[QB] && (ovf[QB] || big);
    if (!nz[QB]) begin
      res.q = '0;
    end else if (ovf[QB] || big) begin
      res.q = TERM_LIMIT;
    end else begin
      res.q = q[QB];
    end
  end

endmodule
